// File: hdl/affine_state_recurrence_unit_defines.svh
// Assertion macros shared by the affine state recurrence RTL
// Depends on clk and rst_n being visible at the point of use
`ifndef AFFINE_STATE_RECURRENCE_UNIT_DEFINES_SVH
`define AFFINE_STATE_RECURRENCE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked at every clock edge outside reset
`define ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle implication violated");

// next-cycle implication, checked at every clock edge outside reset
`define ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication violated");

`else

`define ASSERT_IMP(name, pre, post)
`define ASSERT_NXT(name, pre, post)

`endif

`endif

// File: hdl/asru_pkg.sv
// Package for the affine state recurrence unit: sizes, codes and shared types
// No dependencies
`timescale 1ns / 1ps

package asru_pkg;

    // vector length and data formats
    localparam int POOLS    = 4;
    localparam int VEC_LEN  = 3 * POOLS;
    localparam int IDX_W    = $clog2(VEC_LEN);
    localparam int FIELD_W  = 6;
    localparam int OPC_W    = 2;
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 30;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int ACC_W    = PROD_W + $clog2(VEC_LEN) + 1;
    localparam int RND_W    = ACC_W - FRAC_W;
    localparam int SUM_W    = RND_W + 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VEC_LEN - 1);

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_LOAD_X = 2'd2,
        OP_STEP   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_COPY,
        ST_EMIT
    } state_t;

    // partial row sum travelling down the chain
    typedef struct packed {
        logic                     valid;
        logic [IDX_W-1:0]         row;
        logic signed [ACC_W-1:0]  acc;
    } token_t;

    // element writes into one cell
    typedef struct packed {
        logic                     a_we;
        logic                     x_we;
        logic [IDX_W-1:0]         row;
        logic signed [DATA_W-1:0] data;
    } load_t;

endpackage

// File: hdl/affine_state_recurrence_unit.sv
// A step is accepted while idle; the rows of A*x pass the cell chain, are rounded, offset
// by b, saturated and copied back into x, then N beats follow at one per cycle while the
// receiver takes them. No new item is taken until the step's last beat is loaded for output.
// Each of the N cells in the chain holds a multiply and an accumulate stage.
// Load beats are taken one per cycle while idle and produce no result.
// Reset clears the sequencer and valid flags; A, b and x are undefined until written.
// Top level of the affine state recurrence unit; depends on asru_pkg, asru_cell
// and the assertion macro header
`timescale 1ns / 1ps
`include "affine_state_recurrence_unit_defines.svh"

module affine_state_recurrence_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [asru_pkg::OPC_W-1:0]          opcode,
    input  logic [asru_pkg::FIELD_W-1:0]        row_index,
    input  logic [asru_pkg::FIELD_W-1:0]        col_index,
    input  logic signed [asru_pkg::DATA_W-1:0]  value,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [asru_pkg::FIELD_W-1:0]        element_index,
    output logic signed [asru_pkg::DATA_W-1:0]  element_value,
    output logic                                last
);
    import asru_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI   = (SUM_W'(1) <<< (DATA_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO   = -(SUM_W'(1) <<< (DATA_W - 1));

    state_t                   state_reg;
    state_t                   state_next;
    opcode_t                  op;
    logic                     item_fire;
    logic                     row_ok;
    logic                     col_ok;
    logic [IDX_W-1:0]         row_idx;
    logic                     feed_en;
    logic                     copy_en;
    logic                     emit_en;
    logic                     out_load;
    logic                     fin_last;

    logic [IDX_W-1:0]         feed_cnt_reg;
    logic [IDX_W-1:0]         emit_idx_reg;

    logic signed [DATA_W-1:0] b_reg    [VEC_LEN];
    logic signed [DATA_W-1:0] next_reg [VEC_LEN];

    token_t                   chain [VEC_LEN + 1];
    load_t                    load_bus [VEC_LEN];

    logic signed [ACC_W-1:0]  acc_rounded;
    logic                     rnd_valid_reg;
    logic [IDX_W-1:0]         rnd_row_reg;
    logic signed [RND_W-1:0]  rnd_reg;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DATA_W-1:0] sat;

    logic                     result_valid_reg;
    logic [IDX_W-1:0]         result_idx_reg;
    logic signed [DATA_W-1:0] result_value_reg;
    logic                     result_last_reg;

    // input decode
    assign op        = opcode_t'(opcode);
    assign item_fire = item_valid && !item_stall;
    assign row_ok    = row_index < FIELD_W'(VEC_LEN);
    assign col_ok    = col_index < FIELD_W'(VEC_LEN);
    assign row_idx   = row_index[IDX_W-1:0];

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && op == OP_STEP)
                begin
                    state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                if (feed_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (fin_last)
                begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load && emit_idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        item_stall = 1'b1;
        feed_en    = 1'b0;
        copy_en    = 1'b0;
        emit_en    = 1'b0;
        case (state_reg)
            ST_IDLE:  item_stall = 1'b0;
            ST_FEED:  feed_en    = 1'b1;
            ST_DRAIN: ;
            ST_COPY:  copy_en    = 1'b1;
            ST_EMIT:  emit_en    = 1'b1;
            default:  item_stall = 1'b1;
        endcase
    end

    // row and emit counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_cnt_reg <= '0;
            emit_idx_reg <= '0;
        end
        else
        begin
            if (feed_en)
            begin
                feed_cnt_reg <= (feed_cnt_reg == LAST_IDX) ? '0 : feed_cnt_reg + 1'b1;
            end
            if (out_load)
            begin
                emit_idx_reg <= (emit_idx_reg == LAST_IDX) ? '0 : emit_idx_reg + 1'b1;
            end
        end
    end

    // offset vector
    always_ff @(posedge clk)
    begin
        if (item_fire && op == OP_LOAD_B && row_ok)
        begin
            b_reg[row_idx] <= value;
        end
    end

    // row sums enter the first cell one per cycle
    always_comb
    begin
        chain[0].valid = feed_en;
        chain[0].row   = feed_cnt_reg;
        chain[0].acc   = '0;
    end

    // cell chain, one cell per column
    for (genvar j = 0; j < VEC_LEN; j++)
    begin : g_cell
        always_comb
        begin
            load_bus[j].a_we = item_fire && op == OP_LOAD_A && row_ok && col_ok
                               && col_index == FIELD_W'(j);
            load_bus[j].x_we = copy_en || (item_fire && op == OP_LOAD_X && row_ok
                               && row_index == FIELD_W'(j));
            load_bus[j].row  = row_idx;
            load_bus[j].data = copy_en ? next_reg[j] : value;
        end

        asru_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .load    (load_bus[j]),
            .tok_in  (chain[j]),
            .tok_out (chain[j + 1])
        );
    end

    // round to nearest, ties up
    assign acc_rounded = chain[VEC_LEN].acc + HALF_LSB;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
        end
        else
        begin
            rnd_valid_reg <= chain[VEC_LEN].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_row_reg <= chain[VEC_LEN].row;
        rnd_reg     <= acc_rounded[ACC_W-1:FRAC_W];
    end

    // add offset and saturate
    assign sum = SUM_W'(rnd_reg) + SUM_W'(b_reg[rnd_row_reg]);

    always_comb
    begin
        if (sum > SAT_HI)
        begin
            sat = SAT_HI[DATA_W-1:0];
        end
        else if (sum < SAT_LO)
        begin
            sat = SAT_LO[DATA_W-1:0];
        end
        else
        begin
            sat = sum[DATA_W-1:0];
        end
    end

    assign fin_last = rnd_valid_reg && rnd_row_reg == LAST_IDX;

    // new state vector, copied into the cells once complete
    always_ff @(posedge clk)
    begin
        if (rnd_valid_reg)
        begin
            next_reg[rnd_row_reg] <= sat;
        end
    end

    // output register
    assign out_load = emit_en && (!result_valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_idx_reg   <= emit_idx_reg;
            result_value_reg <= next_reg[emit_idx_reg];
            result_last_reg  <= emit_idx_reg == LAST_IDX;
        end
    end

    assign result_valid  = result_valid_reg;
    assign element_index = FIELD_W'(result_idx_reg);
    assign element_value = result_value_reg;
    assign last          = result_last_reg;

    // chain carries nothing outside a step's compute phase
    `ASSERT_IMP(a_chain_quiet, state_reg == ST_IDLE || state_reg == ST_COPY || state_reg == ST_EMIT, !chain[VEC_LEN].valid)
    // finished rows only arrive while draining
    `ASSERT_IMP(a_round_in_drain, rnd_valid_reg, state_reg == ST_DRAIN)
    // copy hands over to emission starting at element zero
    `ASSERT_NXT(a_copy_then_emit, state_reg == ST_COPY, state_reg == ST_EMIT && emit_idx_reg == '0)
    // the final element closes the step
    `ASSERT_NXT(a_last_closes, out_load && emit_idx_reg == LAST_IDX, state_reg == ST_IDLE && result_last_reg)

endmodule

// File: hdl/asru_cell.sv
// One column cell: holds one column of A and one element of x, adds its product
// to the passing row sum. Depends on asru_pkg
`timescale 1ns / 1ps

module asru_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  asru_pkg::load_t   load,
    input  asru_pkg::token_t  tok_in,
    output asru_pkg::token_t  tok_out
);
    import asru_pkg::*;

    logic signed [DATA_W-1:0] col_reg [VEC_LEN];
    logic signed [DATA_W-1:0] x_reg;
    logic signed [PROD_W-1:0] prod;

    logic                     s1_valid_reg;
    logic [IDX_W-1:0]         s1_row_reg;
    logic signed [ACC_W-1:0]  s1_acc_reg;
    logic signed [PROD_W-1:0] s1_prod_reg;

    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg;
    logic signed [ACC_W-1:0]  out_acc_reg;

    // column of A and state element
    always_ff @(posedge clk)
    begin
        if (load.a_we)
        begin
            col_reg[load.row] <= load.data;
        end
        if (load.x_we)
        begin
            x_reg <= load.data;
        end
    end

    // product of this cell's matrix entry and state element
    assign prod = col_reg[tok_in.row] * x_reg;

    // valid bits of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= tok_in.valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    // multiply stage, then accumulate stage
    always_ff @(posedge clk)
    begin
        s1_row_reg  <= tok_in.row;
        s1_acc_reg  <= tok_in.acc;
        s1_prod_reg <= prod;
        out_row_reg <= s1_row_reg;
        out_acc_reg <= s1_acc_reg + ACC_W'(s1_prod_reg);
    end

    assign tok_out.valid = out_valid_reg;
    assign tok_out.row   = out_row_reg;
    assign tok_out.acc   = out_acc_reg;

endmodule
